[rtl/i2cras_pkg.sv]
// Package for the I2C register access sequencer: operation and command codes,
// the transfer phase type and the default buffer depth. No dependencies.
package i2cras_pkg;

  localparam int DEF_BUF_DEPTH = 16;

  localparam int OP_W   = 2;
  localparam int ADDR_W = 7;
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 5;
  localparam int IDX_W  = 4;
  localparam int CMD_W  = 4;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd2;
  localparam logic [OP_W-1:0] OP_EVENT = 2'd3;

  localparam logic [CMD_W-1:0] CMD_NONE      = 4'd0;
  localparam logic [CMD_W-1:0] CMD_START_RD  = 4'd1;
  localparam logic [CMD_W-1:0] CMD_START_WR  = 4'd2;
  localparam logic [CMD_W-1:0] CMD_SEND      = 4'd3;
  localparam logic [CMD_W-1:0] CMD_SEND_LAST = 4'd4;
  localparam logic [CMD_W-1:0] CMD_AUTOEND   = 4'd5;
  localparam logic [CMD_W-1:0] CMD_RESTART   = 4'd6;
  localparam logic [CMD_W-1:0] CMD_RX_BYTE   = 4'd7;
  localparam logic [CMD_W-1:0] CMD_STOP_DONE = 4'd8;
  localparam logic [CMD_W-1:0] CMD_NACK      = 4'd9;

  typedef enum logic [7:0] {
    PH_IDLE = 8'b0000_0001,
    PH_ADDR = 8'b0000_0010,
    PH_REG  = 8'b0000_0100,
    PH_AUTO = 8'b0000_1000,
    PH_DATA = 8'b0001_0000,
    PH_STOP = 8'b0010_0000,
    PH_OK   = 8'b0100_0000,
    PH_FAIL = 8'b1000_0000
  } phase_t;

endpackage

[rtl/i2c_register_access_sequencer_top.sv]
// I2C register access sequencer: turns buffer loads, start requests and core
// status events into one core command each, through an input and a result register.
// Depends on i2cras_pkg.
//
// Usage: every beat on the in_ channel is one operation (buffer load, start read,
// start write or core status event); every such beat yields exactly one beat on
// the out_ channel carrying a core command and the status bits after that step.
// A start is refused while a transfer is in progress; the byte count is clamped
// to 1..min(BUF_DEPTH, 31). A NACK while busy aborts the transfer.
// A beat taken sits in the input register; its result is computed from there and
// captured in the result register when that register can advance.
// Throughput is one beat per cycle while the receiver does not stall; the state
// update is a single pass of short logic from the input register into the result
// register. When the receiver stalls, the result register holds and the input
// register holds behind it; in_ready drops only when both are full.
// Synchronous reset clears the phase, the flags, the counters and both valid
// bits; the transmit buffer is undefined until loaded.
module i2c_register_access_sequencer_top
  import i2cras_pkg::*;
#(
  parameter int BUF_DEPTH = DEF_BUF_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   in_op,
  input  logic [ADDR_W-1:0] in_dev_addr,
  input  logic [BYTE_W-1:0] in_reg_addr,
  input  logic [CNT_W-1:0]  in_byte_count,
  input  logic [IDX_W-1:0]  in_buf_index,
  input  logic [BYTE_W-1:0] in_buf_byte,
  input  logic              in_flag_txis,
  input  logic              in_flag_tcr,
  input  logic              in_flag_tc,
  input  logic              in_flag_rxne,
  input  logic              in_flag_stopf,
  input  logic              in_flag_nackf,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CMD_W-1:0]  out_cmd,
  output logic [ADDR_W-1:0] out_out_addr,
  output logic [BYTE_W-1:0] out_out_byte,
  output logic [CNT_W-1:0]  out_out_count,
  output logic [IDX_W-1:0]  out_out_index,
  output logic              out_start_accepted,
  output logic              out_busy_now,
  output logic              out_last_ok
);

  localparam int BUF_SLOTS = (BUF_DEPTH < (1 << IDX_W)) ? BUF_DEPTH : (1 << IDX_W);
  localparam int BIDX_W    = (BUF_SLOTS > 1) ? $clog2(BUF_SLOTS) : 1;
  localparam int CNT_MAXI  = (BUF_DEPTH < ((1 << CNT_W) - 1)) ? BUF_DEPTH : ((1 << CNT_W) - 1);
  localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(CNT_MAXI);
  localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(BUF_SLOTS);

  // Input register.
  logic              in_vld_r;
  logic [OP_W-1:0]   op_r;
  logic [ADDR_W-1:0] dev_addr_r;
  logic [BYTE_W-1:0] reg_addr_r;
  logic [CNT_W-1:0]  byte_count_r;
  logic [IDX_W-1:0]  buf_index_r;
  logic [BYTE_W-1:0] buf_byte_r;
  logic              txis_r, tcr_r, tc_r, rxne_r, stopf_r, nackf_r;

  // Sequencer state.
  phase_t            phase_r, phase_nxt;
  logic              is_read_r, is_read_nxt;
  logic              busy_r, busy_nxt;
  logic [ADDR_W-1:0] target_addr_r, target_addr_nxt;
  logic [BYTE_W-1:0] target_reg_r, target_reg_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic [CNT_W-1:0]  done_r, done_nxt;
  logic [BYTE_W-1:0] tx_buf_r [BUF_SLOTS];

  // Result register.
  logic              out_vld_r;
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [ADDR_W-1:0] oaddr_r, oaddr_nxt;
  logic [BYTE_W-1:0] obyte_r, obyte_nxt;
  logic [CNT_W-1:0]  ocount_r, ocount_nxt;
  logic [IDX_W-1:0]  oindex_r, oindex_nxt;
  logic              acc_r, acc_nxt;

  logic              advance;
  logic              commit;
  logic              buf_we;
  logic [BYTE_W-1:0] tx_rd;
  logic [CNT_W-1:0]  cnt_clamp;
  logic [CNT_W-1:0]  done_inc;

  assign advance  = !out_vld_r || out_ready;
  assign in_ready = !in_vld_r || advance;
  assign commit   = in_vld_r && advance;

  assign buf_we   = commit && (op_r == OP_LOAD) && ({1'b0, buf_index_r} < SLOTS_CNT);
  assign tx_rd    = (done_r < SLOTS_CNT) ? tx_buf_r[done_r[BIDX_W-1:0]] : '0;
  assign done_inc = done_r + CNT_W'(1);

  always_comb begin
    priority if (byte_count_r == '0) begin
      cnt_clamp = CNT_W'(1);
    end else if (byte_count_r > CNT_MAX) begin
      cnt_clamp = CNT_MAX;
    end else begin
      cnt_clamp = byte_count_r;
    end
  end

  always_comb begin
    phase_nxt       = phase_r;
    is_read_nxt     = is_read_r;
    busy_nxt        = busy_r;
    target_addr_nxt = target_addr_r;
    target_reg_nxt  = target_reg_r;
    total_nxt       = total_r;
    done_nxt        = done_r;
    cmd_nxt         = CMD_NONE;
    oaddr_nxt       = '0;
    obyte_nxt       = '0;
    ocount_nxt      = '0;
    oindex_nxt      = '0;
    acc_nxt         = 1'b0;
    unique case (op_r)
      OP_LOAD: begin
      end
      OP_READ, OP_WRITE: begin
        if (!busy_r) begin
          busy_nxt        = 1'b1;
          acc_nxt         = 1'b1;
          is_read_nxt     = (op_r == OP_READ);
          target_addr_nxt = dev_addr_r;
          target_reg_nxt  = reg_addr_r;
          total_nxt       = cnt_clamp;
          done_nxt        = '0;
          phase_nxt       = PH_ADDR;
          cmd_nxt         = (op_r == OP_READ) ? CMD_START_RD : CMD_START_WR;
          oaddr_nxt       = dev_addr_r;
        end
      end
      OP_EVENT: begin
        if (busy_r) begin
          priority if (nackf_r) begin
            busy_nxt  = 1'b0;
            phase_nxt = PH_FAIL;
            cmd_nxt   = CMD_NACK;
          end else if (phase_r == PH_ADDR) begin
            if (txis_r) begin
              cmd_nxt   = CMD_SEND;
              obyte_nxt = target_reg_r;
              phase_nxt = PH_REG;
            end
          end else if (phase_r == PH_STOP) begin
            if (stopf_r) begin
              cmd_nxt   = CMD_STOP_DONE;
              busy_nxt  = 1'b0;
              phase_nxt = PH_OK;
            end
          end else if (!is_read_r) begin
            priority if (phase_r == PH_REG) begin
              if (tcr_r) begin
                cmd_nxt   = CMD_AUTOEND;
                phase_nxt = PH_AUTO;
              end
            end else if (phase_r == PH_AUTO) begin
              if (txis_r) begin
                obyte_nxt = tx_rd;
                done_nxt  = done_inc;
                if (total_r == CNT_W'(1)) begin
                  cmd_nxt   = CMD_SEND_LAST;
                  phase_nxt = PH_STOP;
                end else begin
                  cmd_nxt   = CMD_SEND;
                  phase_nxt = PH_DATA;
                end
              end
            end else if (phase_r == PH_DATA) begin
              if (txis_r || tcr_r) begin
                obyte_nxt = tx_rd;
                done_nxt  = done_inc;
                if (total_r <= done_inc) begin
                  cmd_nxt   = CMD_SEND_LAST;
                  phase_nxt = PH_STOP;
                end else begin
                  cmd_nxt = CMD_SEND;
                end
              end
            end else begin
            end
          end else begin
            priority if (phase_r == PH_REG) begin
              if (tc_r) begin
                cmd_nxt    = CMD_RESTART;
                oaddr_nxt  = target_addr_r;
                ocount_nxt = total_r;
                phase_nxt  = PH_DATA;
              end
            end else if (phase_r == PH_DATA) begin
              if (rxne_r) begin
                cmd_nxt    = CMD_RX_BYTE;
                obyte_nxt  = buf_byte_r;
                oindex_nxt = done_r[IDX_W-1:0];
                done_nxt   = done_inc;
                if (done_inc >= total_r) begin
                  phase_nxt = PH_STOP;
                end
              end
            end else begin
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r      <= 1'b0;
      out_vld_r     <= 1'b0;
      phase_r       <= PH_IDLE;
      is_read_r     <= 1'b0;
      busy_r        <= 1'b0;
      target_addr_r <= '0;
      target_reg_r  <= '0;
      total_r       <= '0;
      done_r        <= '0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= in_vld_r;
      end
      if (commit) begin
        phase_r       <= phase_nxt;
        is_read_r     <= is_read_nxt;
        busy_r        <= busy_nxt;
        target_addr_r <= target_addr_nxt;
        target_reg_r  <= target_reg_nxt;
        total_r       <= total_nxt;
        done_r        <= done_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r         <= in_op;
      dev_addr_r   <= in_dev_addr;
      reg_addr_r   <= in_reg_addr;
      byte_count_r <= in_byte_count;
      buf_index_r  <= in_buf_index;
      buf_byte_r   <= in_buf_byte;
      txis_r       <= in_flag_txis;
      tcr_r        <= in_flag_tcr;
      tc_r         <= in_flag_tc;
      rxne_r       <= in_flag_rxne;
      stopf_r      <= in_flag_stopf;
      nackf_r      <= in_flag_nackf;
    end
    if (commit) begin
      cmd_r    <= cmd_nxt;
      oaddr_r  <= oaddr_nxt;
      obyte_r  <= obyte_nxt;
      ocount_r <= ocount_nxt;
      oindex_r <= oindex_nxt;
      acc_r    <= acc_nxt;
    end
    if (buf_we) begin
      tx_buf_r[buf_index_r[BIDX_W-1:0]] <= buf_byte_r;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_cmd            = cmd_r;
  assign out_out_addr       = oaddr_r;
  assign out_out_byte       = obyte_r;
  assign out_out_count      = ocount_r;
  assign out_out_index      = oindex_r;
  assign out_start_accepted = acc_r;
  assign out_busy_now       = busy_r;
  assign out_last_ok        = (phase_r == PH_OK);

`ifndef SYNTHESIS
  a_start_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && acc_r |-> busy_r)
    else $error("accepted start did not leave the block busy");

  a_busy_phase: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (phase_r == PH_ADDR || phase_r == PH_REG || phase_r == PH_AUTO ||
                phase_r == PH_DATA || phase_r == PH_STOP))
    else $error("busy outside an active transfer phase");

  a_done_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (done_r <= total_r))
    else $error("transferred byte count exceeds the requested count");

  a_nack_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (cmd_r == CMD_NACK) |-> (!busy_r && phase_r == PH_FAIL))
    else $error("NACK abort did not end the transfer as failed");
`endif

endmodule
